// ----- rtl/core/rmn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the quarter-wave sine table for the ring modulator.
// No dependencies; imported by every module in rtl/core.
package rmn_pkg;

  localparam int DEF_SAMPLE_BITS  = 24;
  localparam int DEF_PHASE_BITS   = 32;
  // Sine table size is fixed here: the table is built at elaboration from it.
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int QTR_LEN          = SINE_TABLE_DEPTH / 4;
  localparam int SIDX_BITS        = $clog2(QTR_LEN);
  localparam int TIDX_BITS        = $clog2(QTR_LEN + 1);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 31;
  localparam int STEP_BITS     = 31;
  localparam int WET_BITS      = 16;
  localparam int CAR_BITS      = 16;
  // carrier minus full scale, and the wet level as a signed operand
  localparam int COFF_BITS     = 17;
  localparam int K_BITS        = 33;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd39370534;
  localparam logic [WET_BITS-1:0]  WET_RESET  = 16'd16384;
  localparam logic [WET_BITS-1:0]  FULL_WET   = 16'd32768;
  localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP  = 2'd0,
    CFG_SHAPE = 2'd1,
    CFG_WET   = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_TRI    = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MULW  = 2'd1,
    ST_MULX  = 2'd2,
    ST_ROUND = 2'd3
  } st_e;

  typedef logic [CAR_BITS-2:0] sine_tab_t [0:QTR_LEN];

  localparam logic [63:0] TAYLOR_DIV [0:6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210};

  // Q30 Taylor series to x^15, scaled to Q15 with round half up
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    logic [63:0] e;
    for (int k = 0; k <= QTR_LEN; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / QTR_LEN;
      term = x;
      sum  = longint'(x);
      for (int n = 0; n < 7; n++) begin
        term = ((((term * x) >> 30) * x) >> 30) / TAYLOR_DIV[n];
        if (n % 2 == 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      e = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tab[k] = e[CAR_BITS-2:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ----- rtl/core/rmn_carrier.sv -----
`timescale 1ns / 1ps
// Carrier waveform generator: sine, saw, square or triangle from the oscillator phase.
// Depends on rmn_pkg (sine table, wave codes).
module rmn_carrier import rmn_pkg::*; #(
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic [PHASE_BITS-1:0]      phase_i,
  input  wave_e                      shape_i,
  output logic signed [CAR_BITS-1:0] carrier_o
);

  logic [15:0]           u;
  logic [1:0]            quad;
  logic [SIDX_BITS-1:0]  s;
  logic [TIDX_BITS-1:0]  idx;
  logic [CAR_BITS-2:0]   mag;
  logic signed [17:0]    tri_v;

  assign u    = phase_i[PHASE_BITS-1 -: 16];
  assign quad = phase_i[PHASE_BITS-1 -: 2];
  assign s    = phase_i[PHASE_BITS-3 -: SIDX_BITS];

  always_comb begin
    // odd quadrants read the table backwards
    idx = quad[0] ? TIDX_BITS'(QTR_LEN) - TIDX_BITS'(s) : TIDX_BITS'(s);
    mag = SINE_TAB[idx];
    if (u[15]) begin
      tri_v = 18'sd98303 - $signed({1'b0, u, 1'b0});
    end else begin
      tri_v = $signed({1'b0, u, 1'b0}) - 18'sd32767;
    end
    case (shape_i)
      WAVE_SINE:   carrier_o = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      WAVE_SAW:    carrier_o = $signed({~u[15], u[14:0]});
      WAVE_SQUARE: carrier_o = u[15] ? -16'sd32767 : 16'sd32767;
      WAVE_TRI:    carrier_o = tri_v[CAR_BITS-1:0];
      default:     carrier_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/rmn_mul.sv -----
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product.
// Depends on rmn_pkg for the default operand widths.
module rmn_mul import rmn_pkg::*; #(
  parameter int A_BITS = DEF_SAMPLE_BITS,
  parameter int B_BITS = K_BITS
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [A_BITS-1:0]        a_i,
  input  logic signed [B_BITS-1:0]        b_i,
  output logic signed [A_BITS+B_BITS-1:0] p_o
);

  logic signed [A_BITS+B_BITS-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/ring_modulator_nco_core.sv -----
`timescale 1ns / 1ps
// Ring modulator with a phase-accumulator carrier; top level.
// Depends on rmn_pkg, rmn_carrier and rmn_mul.
// Each accepted sample goes through the transaction cycle, where the carrier is
// sampled and the phase advances, then two passes through the single shared multiplier
// (wet level times carrier offset, then sample times that) and a round-and-saturate
// cycle that loads the output register once it is free. The input stalls outside idle,
// so no new sample is taken before the last one has loaded the output register; a result
// waiting on a stalled output does not hold off the next sample until its round cycle.
// The mix is out = x + round(x * w * (c - 2^15) / 2^30), which equals the dry/wet blend.
// Configuration writes are always ready and must only be issued while the block is idle.
module ring_modulator_nco_core import rmn_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int PHASE_BITS  = DEF_PHASE_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] out_sample_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i
);

  localparam int MA_BITS  = (SAMPLE_BITS > COFF_BITS) ? SAMPLE_BITS : COFF_BITS;
  localparam int ACC_BITS = MA_BITS + K_BITS;
  localparam int Y_BITS   = ACC_BITS - 28;
  localparam logic signed [Y_BITS-1:0] SMAX = Y_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_BITS-1:0] SMIN = -SMAX - 1;
  localparam logic signed [ACC_BITS:0] ROUND_HALF = (ACC_BITS + 1)'(64'sd1 <<< 29);

  st_e state_q, state_d;

  logic [STEP_BITS-1:0]  step_q;
  wave_e                 shape_q;
  logic [WET_BITS-1:0]   wet_q;
  logic [PHASE_BITS-1:0] phase_q;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [COFF_BITS-1:0]   c_off_q;
  logic signed [SAMPLE_BITS-1:0] out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic signed [CAR_BITS-1:0]  carrier;
  logic [WET_BITS-1:0]         wet_clamped;
  logic                        in_take;
  logic                        mul_en;
  logic signed [MA_BITS-1:0]   mul_a;
  logic signed [K_BITS-1:0]    mul_b;
  logic signed [ACC_BITS-1:0]  prod;
  logic signed [ACC_BITS:0]    rsum;
  logic signed [Y_BITS-1:0]    y;

  rmn_carrier #(
    .PHASE_BITS(PHASE_BITS)
  ) u_carrier (
    .phase_i  (phase_q),
    .shape_i  (shape_q),
    .carrier_o(carrier)
  );

  rmn_mul #(
    .A_BITS(MA_BITS),
    .B_BITS(K_BITS)
  ) u_mul (
    .clk_i(clk_i),
    .en_i (mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign wet_clamped = (wet_q > FULL_WET) ? FULL_WET : wet_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      shape_q <= WAVE_SINE;
      wet_q   <= WET_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP:  step_q  <= cfg_data_i[STEP_BITS-1:0];
        CFG_SHAPE: shape_q <= wave_e'(cfg_data_i[1:0]);
        CFG_WET:   wet_q   <= cfg_data_i[WET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // phase accumulator, wraps naturally at the register width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (in_take) begin
      phase_q <= phase_q + PHASE_BITS'({{PHASE_BITS{1'b0}}, step_q});
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      x_q     <= in_sample_i;
      c_off_q <= COFF_BITS'(carrier) - 17'sd32768;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // rounding: floor((acc + 2^29) / 2^30) added to the dry sample, then saturation
  always_comb begin
    rsum = {prod[ACC_BITS-1], prod} + ROUND_HALF;
    y    = Y_BITS'(x_q) + Y_BITS'($signed(rsum[ACC_BITS:30]));
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mul_en      = 1'b0;
    mul_a       = MA_BITS'(x_q);
    mul_b       = prod[K_BITS-1:0];
    case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_MULW;
        end
      end
      ST_MULW: begin
        mul_en  = 1'b1;
        mul_a   = MA_BITS'(c_off_q);
        mul_b   = $signed(K_BITS'({1'b0, wet_clamped}));
        state_d = ST_MULX;
      end
      ST_MULX: begin
        mul_en  = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d = 1'b1;
          if (y > SMAX) begin
            out_d = SAMPLE_BITS'(SMAX);
          end else if (y < SMIN) begin
            out_d = SAMPLE_BITS'(SMIN);
          end else begin
            out_d = SAMPLE_BITS'(y);
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;

  a_take_starts_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> state_q == ST_MULW)
    else $error("accepted sample did not start the multiply sequence");

  a_phase_only_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_take |=> $stable(phase_q))
    else $error("phase moved without an input transaction");

  a_round_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && !(out_valid_q && out_stall_i)) |=> out_valid_q && state_q == ST_IDLE)
    else $error("round cycle did not load the output register");

  a_wet_term_nonpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULX |-> (prod[ACC_BITS-1] || prod == '0))
    else $error("wet times carrier offset must not be positive");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ring_modulator_nco_core: directed and random samples,
// with a built-in carrier/mix predictor. Depends on rmn_pkg and the core RTL.
module testbench;
  import rmn_pkg::*;

  localparam int SW = DEF_SAMPLE_BITS;
  localparam int PB = DEF_PHASE_BITS;
  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall_o;
  logic signed [SW-1:0]     in_sample = '0;
  logic                     out_valid_o;
  logic                     out_stall = 1'b0;
  logic signed [SW-1:0]     out_sample_o;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  ring_modulator_nco_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .in_sample_i  (in_sample),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .out_sample_o (out_sample_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // predictor copy of the block's registers and oscillator
  logic [STEP_BITS-1:0] step_cfg  = STEP_RESET;
  wave_e                shape_cfg = WAVE_SINE;
  logic [WET_BITS-1:0]  wet_cfg   = WET_RESET;
  logic [PB-1:0]        phase_acc = '0;
  int                   quarter_sine [0:QTR_LEN];

  logic signed [SW-1:0] sample_queue [$];
  logic signed [SW-1:0] expected_out [$];
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   mismatches = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // carrier lookup, blend, round and saturate; advances the phase
  function automatic logic signed [SW-1:0] ring_mod_sample(logic signed [SW-1:0] x);
    logic [15:0] u;
    logic [1:0]  quad;
    int          s;
    int          v;
    int          c;
    longint      w;
    longint      d;
    longint      acc;
    longint      y;
    u = phase_acc[PB-1 -: 16];
    case (shape_cfg)
      WAVE_SINE: begin
        quad = phase_acc[PB-1 -: 2];
        s = int'((64'(phase_acc[PB-3:0]) * QTR_LEN) >> (PB - 2));
        if (s > QTR_LEN) s = QTR_LEN;
        v = quad[0] ? quarter_sine[QTR_LEN - s] : quarter_sine[s];
        c = quad[1] ? -v : v;
      end
      WAVE_SAW:    c = int'(u) - 32768;
      WAVE_SQUARE: c = phase_acc[PB-1] ? -32767 : 32767;
      default:     c = (u < 16'd32768) ? -32767 + 2 * int'(u) : 32767 - 2 * (int'(u) - 32768);
    endcase
    w = (wet_cfg > FULL_WET) ? 32768 : longint'(wet_cfg);
    d = 32768 - w;
    acc = longint'(x) * d * 32768 + longint'(x) * c * w;
    y = (acc + 64'sd536870912) >>> 30;
    if (y > longint'(S_MAX)) y = longint'(S_MAX);
    if (y < longint'(S_MIN)) y = longint'(S_MIN);
    phase_acc = phase_acc + PB'(step_cfg);
    return y[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return SW'($urandom_range(0, 511)) - SW'(256);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] rand_step();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return STEP_BITS'($urandom_range(1, 65535));
      3:       return STEP_BITS'($urandom_range(1 << 20, 1 << 26));
      default: return STEP_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WET_BITS-1:0] rand_wet();
    case ($urandom_range(3))
      0:       return '0;
      1:       return FULL_WET;
      2:       return WET_BITS'($urandom_range(0, 32768));
      default: return WET_BITS'($urandom_range(32769, 65535));
    endcase
  endfunction

  // upper data bits are random so that field masking gets exercised
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] val);
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'($urandom);
    case (idx)
      CFG_STEP:  data = val;
      CFG_SHAPE: data[1:0] = val[1:0];
      CFG_WET:   data[WET_BITS-1:0] = val[WET_BITS-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STEP:  step_cfg  = data;
      CFG_SHAPE: shape_cfg = wave_e'(data[1:0]);
      CFG_WET:   wet_cfg   = data[WET_BITS-1:0];
      default: ;
    endcase
  endtask

  // nothing queued, nothing in flight, plus a settling margin
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_valid || expected_out.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic queue_sample(logic signed [SW-1:0] smp);
    sample_queue.insert(sample_queue.size(), smp);
  endtask

  task automatic push_random(int n);
    repeat (n) queue_sample(rand_sample());
  endtask

  // sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_out.insert(expected_out.size(), ring_mod_sample(in_sample));
      end
      if (!in_valid || !in_stall_o) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : result_mon
    logic signed [SW-1:0] want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_out.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: out_sample %0d", out_sample_o);
        end else begin
          want = expected_out.pop_front();
          if (out_sample_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("out_sample mismatch: expected %0d, got %0d", want, out_sample_o);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    longint unsigned xq;
    longint unsigned term;
    longint unsigned e;
    longint          tsum;
    logic [PB:0]     gap;

    // quarter-wave sine, Q30 Taylor series scaled to Q15
    for (int k = 0; k <= QTR_LEN; k++) begin
      xq   = (HALF_PI_Q30 * 64'(k)) / 64'(QTR_LEN);
      term = xq;
      tsum = longint'(xq);
      for (int n = 1; n <= 7; n++) begin
        term = ((((term * xq) >> 30) * xq) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) tsum = tsum - longint'(term);
        else            tsum = tsum + longint'(term);
      end
      if (tsum < 0) tsum = 0;
      e = ($unsigned(tsum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) e = 64'd32767;
      quarter_sine[k] = int'(e);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    send_idle_pct = 17;
    recv_idle_pct = 66;

    // reset configuration, untouched
    queue_sample('0);
    queue_sample(S_MAX);
    queue_sample(S_MIN);
    queue_sample(SW'(-1));
    queue_sample(SW'(1));
    queue_sample(SW'(24'h555555));
    queue_sample(SW'(24'hAAAAAA));
    wait_idle();

    // bring the phase round to zero, then hold it: saw gives a carrier of -1
    gap = {1'b0, PB'(0) - phase_acc} + 1'b1;
    write_reg(CFG_STEP, STEP_BITS'(gap >> 1));
    write_reg(CFG_SHAPE, CFG_DATA_BITS'(WAVE_SAW));
    write_reg(CFG_WET, CFG_DATA_BITS'(FULL_WET));
    push_random(2);
    wait_idle();
    write_reg(CFG_STEP, '0);
    queue_sample(S_MIN);
    queue_sample(S_MAX);
    queue_sample(SW'(24'h400000));
    wait_idle();

    // wet beyond full is clamped
    write_reg(CFG_WET, CFG_DATA_BITS'(16'hFFFF));
    queue_sample(S_MIN);
    queue_sample(S_MAX);
    wait_idle();

    // fully dry, and a write to the unused index must change nothing
    write_reg(CFG_WET, '0);
    write_reg(CFG_NONE, CFG_DATA_BITS'($urandom));
    queue_sample(S_MIN);
    queue_sample(S_MAX);
    queue_sample(SW'(12345));
    wait_idle();

    // largest step wraps the phase on every other sample
    write_reg(CFG_STEP, '1);
    write_reg(CFG_WET, CFG_DATA_BITS'(FULL_WET));
    write_reg(CFG_SHAPE, CFG_DATA_BITS'(WAVE_SQUARE));
    push_random(3);
    wait_idle();
    write_reg(CFG_SHAPE, CFG_DATA_BITS'(WAVE_TRI));
    push_random(3);
    wait_idle();
    write_reg(CFG_SHAPE, CFG_DATA_BITS'(WAVE_SINE));
    push_random(3);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 17;
        recv_idle_pct = 66;
      end else if (p < 8) begin
        send_idle_pct = 66;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_STEP, (p == 0) ? '1 : (p == 1) ? '0 : rand_step());
      write_reg(CFG_SHAPE, CFG_DATA_BITS'(p % 4));
      write_reg(CFG_WET, CFG_DATA_BITS'((p == 0) ? '0 : (p == 1) ? 16'hFFFF : rand_wet()));
      if ($urandom_range(3) == 0) write_reg(CFG_NONE, CFG_DATA_BITS'($urandom));
      push_random(77);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
